// ===== hdl/otsu_pkg.sv =====
// shared types and constants of the otsu threshold binarizer
package otsu_pkg;

    localparam int PIX_W       = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [PIX_W-1:0] CUTOFF_RESET = 8'd50;
    localparam logic [PIX_W-1:0] WHITE        = 8'hFF;
    localparam logic [PIX_W-1:0] BLACK        = 8'h00;

    // operation field of an input item
    localparam logic OP_ACC = 1'b0;
    localparam logic OP_BIN = 1'b1;

    // result kind of an output item
    localparam logic RESULT_THR = 1'b0;
    localparam logic RESULT_BIN = 1'b1;

    // work kinds carried through the queue
    localparam logic [1:0] KIND_ACC     = 2'd0;
    localparam logic [1:0] KIND_ACC_END = 2'd1;
    localparam logic [1:0] KIND_BIN     = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PIX_W-1:0] pixel;
    } item_t;

endpackage

// ===== hdl/otsu_front.sv =====
// input side: classifies pixels and buffers them in a short queue
module otsu_front import otsu_pkg::*; #(
    parameter int LEVELS = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             s_tlast,
    input  logic             q_pop,
    output logic             q_valid,
    output item_t            q_item
);

    localparam logic [PIX_W:0] LAST_LEVEL = (PIX_W+1)'(LEVELS - 1);

    item_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                push;
    item_t               in_item;

    assign s_tready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb begin
        if (s_tuser == OP_BIN) begin
            in_item.kind  = KIND_BIN;
            in_item.pixel = s_tdata;
        end else begin
            in_item.kind = s_tlast ? KIND_ACC_END : KIND_ACC;
            // pixels beyond the histogram land in the top bin
            if ({1'b0, s_tdata} > LAST_LEVEL) begin
                in_item.pixel = LAST_LEVEL[PIX_W-1:0];
            end else begin
                in_item.pixel = s_tdata;
            end
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/otsu_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle, stops when the rest is zero
module otsu_mul import otsu_pkg::*; #(
    parameter int AW = 144,
    parameter int BW = 72
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            done,
    output logic [AW+BW-1:0] prod
);

    localparam int PW = AW + BW;

    logic            busy_reg, busy_next;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   a_reg;
    logic [BW-1:0]   b_reg;

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_comb begin
        if (start) begin
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= PW'(a);
            b_reg   <= b;
        end else if (busy_reg && (b_reg != '0)) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

// ===== hdl/otsu_back.sv =====
// work side: histogram memory, threshold search sequencer and result register
module otsu_back import otsu_pkg::*; #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PIX_W-1:0]   cutoff,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2*PIX_W-1:0] m_tdata,
    output logic               m_tuser
);

    localparam int LB  = $clog2(LEVELS);
    localparam int WB  = COUNT_BITS + LB;
    localparam int SB  = WB + LB;
    localparam int DB  = WB + SB;
    localparam int D2B = 2 * DB;
    localparam int XB  = 2 * WB;
    localparam int PW  = D2B + DB;

    localparam logic [LB-1:0]  IDX_LAST  = LB'(LEVELS - 1);
    localparam logic [LB-1:0]  IDX_PEN   = LB'(LEVELS - 2);
    localparam logic [PIX_W:0] LAST9     = (PIX_W+1)'(LEVELS - 1);
    localparam logic [PIX_W:0] MAX9      = (PIX_W+1)'(255);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UPD     = 4'd1;
    localparam logic [3:0] ST_CHK     = 4'd2;
    localparam logic [3:0] ST_TOT_RD  = 4'd3;
    localparam logic [3:0] ST_TOT_ACC = 4'd4;
    localparam logic [3:0] ST_SC_RD   = 4'd5;
    localparam logic [3:0] ST_SC_ACC  = 4'd6;
    localparam logic [3:0] ST_MGO     = 4'd7;
    localparam logic [3:0] ST_MWAIT   = 4'd8;
    localparam logic [3:0] ST_NEXT    = 4'd9;
    localparam logic [3:0] ST_EMIT    = 4'd10;

    localparam logic [2:0] MS_P   = 3'd0;
    localparam logic [2:0] MS_Q   = 3'd1;
    localparam logic [2:0] MS_D2  = 3'd2;
    localparam logic [2:0] MS_X   = 3'd3;
    localparam logic [2:0] MS_LHS = 3'd4;
    localparam logic [2:0] MS_RHS = 3'd5;

    logic [COUNT_BITS-1:0] hist_mem [LEVELS];
    logic [LEVELS-1:0]     vld_reg;
    logic [COUNT_BITS-1:0] rd_q;
    logic                  vld_q;
    logic [LB-1:0]         rd_addr;
    logic                  hist_we;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic [COUNT_BITS-1:0] cnt;
    logic [SB-1:0]         cnt_x_idx;

    logic [3:0]        state_reg;
    logic [2:0]        mstep_reg;
    logic [LB-1:0]     idx_reg;
    logic [LB-1:0]     addr_reg;
    logic              end_reg;
    logic              first_reg;
    logic [PIX_W-1:0]  best_reg;
    logic [PIX_W-1:0]  thr_reg;
    logic [WB-1:0]     wt_reg, w0_reg;
    logic [SB-1:0]     st_reg, s0_reg;
    logic [DB-1:0]     p_reg, q_reg;
    logic [D2B-1:0]    d2_reg, bd2_reg;
    logic [XB-1:0]     x_reg, bx_reg;
    logic [PW-1:0]     lhs_reg, rhs_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [2*PIX_W-1:0] out_data_reg;
    logic               out_free;

    logic [WB-1:0]  w1;
    logic [SB-1:0]  s1;
    logic [DB-1:0]  dabs;
    logic [D2B-1:0] mul_a;
    logic [DB-1:0]  mul_b;
    logic           mul_start;
    logic           mul_done;
    logic [PW-1:0]  mul_prod;
    logic [PIX_W:0] cut_inc;
    logic           last_cand;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign q_pop = (state_reg == ST_IDLE) && q_valid &&
                   ((q_item.kind != KIND_BIN) || out_free);

    assign cnt       = vld_q ? rd_q : '0;
    assign cnt_x_idx = SB'(cnt) * SB'(idx_reg);
    assign hist_we   = (state_reg == ST_UPD);
    assign hist_wdata = (cnt == '1) ? cnt : cnt + 1'b1;

    assign w1        = wt_reg - w0_reg;
    assign s1        = st_reg - s0_reg;
    assign dabs      = (p_reg >= q_reg) ? p_reg - q_reg : q_reg - p_reg;
    assign mul_start = (state_reg == ST_MGO);
    assign cut_inc   = {1'b0, cutoff} + 1'b1;
    assign last_cand = (idx_reg == IDX_PEN);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_addr = q_item.pixel[LB-1:0];
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_comb begin
        case (mstep_reg)
            MS_P: begin
                mul_a = D2B'(s0_reg);
                mul_b = DB'(w1);
            end
            MS_Q: begin
                mul_a = D2B'(s1);
                mul_b = DB'(w0_reg);
            end
            MS_D2: begin
                mul_a = D2B'(dabs);
                mul_b = dabs;
            end
            MS_X: begin
                mul_a = D2B'(w0_reg);
                mul_b = DB'(w1);
            end
            MS_LHS: begin
                mul_a = d2_reg;
                mul_b = DB'(bx_reg);
            end
            MS_RHS: begin
                mul_a = bd2_reg;
                mul_b = DB'(x_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otsu_mul #(
        .AW (D2B),
        .BW (DB)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // histogram storage, read data registered
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[addr_reg] <= hist_wdata;
        end
        rd_q  <= hist_mem[rd_addr];
        vld_q <= vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
            mstep_reg     <= MS_P;
            first_reg     <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (q_item.kind == KIND_BIN) begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= RESULT_BIN;
                            out_data_reg  <= {(q_item.pixel >= thr_reg) ? WHITE : BLACK,
                                              BLACK};
                        end else begin
                            addr_reg  <= q_item.pixel[LB-1:0];
                            end_reg   <= (q_item.kind == KIND_ACC_END);
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    vld_reg[addr_reg] <= 1'b1;
                    state_reg <= end_reg ? ST_CHK : ST_IDLE;
                end
                ST_CHK: begin
                    if (cut_inc > LAST9) begin
                        // no candidate level above the cutoff
                        thr_reg   <= (cut_inc > MAX9) ? WHITE : cut_inc[PIX_W-1:0];
                        vld_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg   <= cutoff[LB-1:0];
                        wt_reg    <= '0;
                        st_reg    <= '0;
                        state_reg <= ST_TOT_RD;
                    end
                end
                ST_TOT_RD: begin
                    state_reg <= ST_TOT_ACC;
                end
                ST_TOT_ACC: begin
                    wt_reg <= wt_reg + WB'(cnt);
                    st_reg <= st_reg + cnt_x_idx;
                    if (idx_reg == IDX_LAST) begin
                        idx_reg   <= cutoff[LB-1:0];
                        w0_reg    <= '0;
                        s0_reg    <= '0;
                        first_reg <= 1'b1;
                        best_reg  <= cut_inc[PIX_W-1:0];
                        state_reg <= ST_SC_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TOT_RD;
                    end
                end
                ST_SC_RD: begin
                    state_reg <= ST_SC_ACC;
                end
                ST_SC_ACC: begin
                    // lower class grows by the bin just below the candidate
                    w0_reg    <= w0_reg + WB'(cnt);
                    s0_reg    <= s0_reg + cnt_x_idx;
                    mstep_reg <= MS_P;
                    state_reg <= ST_MGO;
                end
                ST_MGO: begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mul_done) begin
                        case (mstep_reg)
                            MS_P: begin
                                p_reg     <= mul_prod[DB-1:0];
                                mstep_reg <= MS_Q;
                                state_reg <= ST_MGO;
                            end
                            MS_Q: begin
                                q_reg     <= mul_prod[DB-1:0];
                                mstep_reg <= MS_D2;
                                state_reg <= ST_MGO;
                            end
                            MS_D2: begin
                                d2_reg    <= mul_prod[D2B-1:0];
                                mstep_reg <= MS_X;
                                state_reg <= ST_MGO;
                            end
                            MS_X: begin
                                x_reg     <= mul_prod[XB-1:0];
                                state_reg <= ST_NEXT;
                            end
                            MS_LHS: begin
                                lhs_reg   <= mul_prod;
                                mstep_reg <= MS_RHS;
                                state_reg <= ST_MGO;
                            end
                            default: begin
                                rhs_reg   <= mul_prod;
                                state_reg <= ST_NEXT;
                            end
                        endcase
                    end
                end
                ST_NEXT: begin
                    if ((mstep_reg == MS_X) && !first_reg && (x_reg != '0) &&
                        (bx_reg != '0)) begin
                        // both weight products nonzero: cross-multiplied compare
                        mstep_reg <= MS_LHS;
                        state_reg <= ST_MGO;
                    end else begin
                        if (first_reg ||
                            ((mstep_reg == MS_X) && (x_reg != '0) && (d2_reg != '0)) ||
                            ((mstep_reg == MS_RHS) && (lhs_reg > rhs_reg))) begin
                            if (!first_reg) begin
                                best_reg <= PIX_W'(idx_reg) + 1'b1;
                            end
                            bd2_reg <= d2_reg;
                            bx_reg  <= x_reg;
                        end
                        first_reg <= 1'b0;
                        if (last_cand) begin
                            thr_reg   <= (first_reg) ? best_reg :
                                         (((mstep_reg == MS_X) && (x_reg != '0) &&
                                           (d2_reg != '0)) ||
                                          ((mstep_reg == MS_RHS) && (lhs_reg > rhs_reg)))
                                         ? PIX_W'(idx_reg) + 1'b1 : best_reg;
                            vld_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_SC_RD;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= RESULT_THR;
                        out_data_reg  <= {BLACK, thr_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/otsu_threshold_binarizer.sv =====
// binarize: queue, then output register; one pixel per cycle while receiver is ready
// accumulate: histogram read, then update of one memory port; next item waits for it
// frame end: totals and class sums over the levels from the cutoff up, plus per
// candidate level up to 6 serial multiplies on the shift-and-add multiplier
// reset: histogram empty, cutoff 50, threshold 0, output channel idle
module otsu_threshold_binarizer import otsu_pkg::*; #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,   // pixel
    input  logic               s_tuser,   // operation
    input  logic               s_tlast,   // frame_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2*PIX_W-1:0] m_tdata,   // threshold_level, binary_pixel
    output logic               m_tuser,   // result_kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PIX_W-1:0]   cfg_data   // background_cutoff
);

    logic [PIX_W-1:0] cutoff_reg;
    logic             q_valid;
    logic             q_pop;
    item_t            q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cutoff_reg <= cfg_data;
        end
    end

    otsu_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    otsu_back #(
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cutoff   (cutoff_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_bin_format: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == RESULT_BIN)) |->
        (((m_tdata[15:8] == WHITE) || (m_tdata[15:8] == BLACK)) && (m_tdata[7:0] == BLACK)))
        else $error("binarized transaction malformed");

    a_thr_format: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == RESULT_THR)) |-> (m_tdata[15:8] == BLACK))
        else $error("threshold transaction carries a pixel value");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ===== verif/otsu_checker.sv =====
// result checker: histogram and threshold predictor plus output comparison
module otsu_checker import otsu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,
    input  logic               s_tuser,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [2*PIX_W-1:0] m_tdata,
    input  logic               m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [PIX_W-1:0]   cfg_data,
    output int                 err_count,
    output int                 pending,
    output int                 thr_seen,
    output int                 bin_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = 256;
    localparam longint COUNT_MAX = (64'd1 << 24) - 1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] bpix;
    } result_t;

    longint unsigned hist[LEVELS];
    logic [PIX_W-1:0] cur_thr;
    logic [PIX_W-1:0] cutoff;
    result_t expected_results[$];

    assign pending = expected_results.size();

    task automatic report(input string what, input result_t got, input result_t want);
        $display("mismatch %s: got kind %0d thr %0d pix %0d, want kind %0d thr %0d pix %0d",
                 what, got.kind, got.level, got.bpix, want.kind, want.level, want.bpix);
        err_count++;
    endtask

    // products reach about 2^202, so compare in 256-bit integers
    function automatic logic [7:0] otsu_level(input logic [7:0] c);
        logic [255:0] wt, st, w0, s0, w1, s1, p, q, d, d2, x, bd2, bx;
        logic [8:0] best;
        logic better;
        wt = '0; st = '0; w0 = '0; s0 = '0;
        if (int'(c) + 1 > LEVELS - 1)
            return 8'hFF;
        for (int i = int'(c); i < LEVELS; i++) begin
            wt += 256'(hist[i]);
            st += 256'(hist[i]) * 256'(i);
        end
        best = {1'b0, c} + 9'd1;
        bd2 = '0;
        bx = '0;
        for (int t = int'(c) + 1; t < LEVELS; t++) begin
            w0 += 256'(hist[t-1]);
            s0 += 256'(hist[t-1]) * 256'(t - 1);
            w1 = wt - w0;
            s1 = st - s0;
            p = w1 * s0;
            q = w0 * s1;
            d = (p >= q) ? p - q : q - p;
            d2 = d * d;
            x = w0 * w1;
            if (t == int'(c) + 1) begin
                bd2 = d2;
                bx = x;
            end else begin
                if (x == '0)
                    better = 0;
                else if (bx == '0)
                    better = (d2 != '0);
                else
                    better = (d2 * bx) > (bd2 * x);
                if (better) begin
                    best = 9'(t);
                    bd2 = d2;
                    bx = x;
                end
            end
        end
        return best[7:0];
    endfunction

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            foreach (hist[i]) hist[i] = 0;
            cur_thr = '0;
            cutoff = CUTOFF_RESET;
            expected_results.delete();
            err_count = 0;
            thr_seen = 0;
            bin_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                cutoff = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_BIN) begin
                    want.kind = RESULT_BIN;
                    want.level = '0;
                    want.bpix = (s_tdata >= cur_thr) ? WHITE : BLACK;
                    expected_results.push_back(want);
                end else begin
                    if (hist[s_tdata] < COUNT_MAX)
                        hist[s_tdata]++;
                    if (s_tlast) begin
                        cur_thr = otsu_level(cutoff);
                        foreach (hist[i]) hist[i] = 0;
                        want.kind = RESULT_THR;
                        want.level = cur_thr;
                        want.bpix = '0;
                        expected_results.push_back(want);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.level = m_tdata[7:0];
                got.bpix = m_tdata[15:8];
                if (got.kind == RESULT_THR) thr_seen++;
                else bin_seen++;
                if (expected_results.size() == 0) begin
                    want = '0;
                    report("unexpected result", got, want);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind)
                        report("result kind", got, want);
                    else if (got.level != want.level)
                        report("threshold level", got, want);
                    else if (got.bpix != want.bpix)
                        report("binary pixel", got, want);
                end
            end
        end
    end
endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the otsu threshold binarizer
module tb;
    import otsu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0, s_tuser = 0, s_tlast = 0;
    logic [PIX_W-1:0] s_tdata = '0;
    logic s_tready;
    logic m_tvalid, m_tuser;
    logic m_tready = 0;
    logic [2*PIX_W-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [PIX_W-1:0] cfg_data = '0;
    int err_count, pending, thr_seen, bin_seen;
    bit calm = 0;
    int sent = 0;

    always #2 aclk = ~aclk;

    otsu_threshold_binarizer DUT (.*);
    otsu_checker checker_i (.*);

    // receiver stalls, none during the calm stretch
    always @(posedge aclk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

    task automatic send_pixel(input logic op, input logic [7:0] px, input logic fe);
        while (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= px;
        s_tlast <= fe;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic pause_idle();
        s_tvalid <= 0;
        s_tlast <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300000) @(posedge aclk);
    endtask

    task automatic write_cutoff(input logic [7:0] v);
        pause_idle();
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
    endtask

    // a frame of random pixels, mostly a two-mode image, then some binarized pixels
    task automatic run_frame(input int npix, input int nbin);
        int lo, hi;
        logic [7:0] px;
        lo = $urandom_range(255);
        hi = $urandom_range(255);
        for (int i = 0; i < npix; i++) begin
            case ($urandom_range(3))
                0: px = 8'($urandom_range(255));
                1: px = 8'((lo + $urandom_range(8)) & 8'hFF);
                default: px = 8'((hi + $urandom_range(8)) & 8'hFF);
            endcase
            send_pixel(OP_ACC, px, i == npix - 1);
        end
        for (int i = 0; i < nbin; i++)
            send_pixel(OP_BIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: default cutoff, empty foreground, extremes
        send_pixel(OP_BIN, 8'd0, 1'b0);
        send_pixel(OP_BIN, 8'd255, 1'b1);
        send_pixel(OP_ACC, 8'd0, 1'b1);
        send_pixel(OP_BIN, 8'd50, 1'b0);
        send_pixel(OP_BIN, 8'd51, 1'b0);
        send_pixel(OP_ACC, 8'd60, 1'b0);
        send_pixel(OP_ACC, 8'd60, 1'b0);
        send_pixel(OP_ACC, 8'd200, 1'b0);
        send_pixel(OP_ACC, 8'd255, 1'b1);
        send_pixel(OP_BIN, 8'd199, 1'b0);
        send_pixel(OP_BIN, 8'd255, 1'b0);
        write_cutoff(8'd0);
        send_pixel(OP_ACC, 8'd0, 1'b0);
        send_pixel(OP_ACC, 8'd255, 1'b1);
        send_pixel(OP_BIN, 8'd128, 1'b0);
        write_cutoff(8'd254);
        send_pixel(OP_ACC, 8'd255, 1'b0);
        send_pixel(OP_ACC, 8'd254, 1'b1);
        write_cutoff(8'd255);
        send_pixel(OP_ACC, 8'd255, 1'b1);
        send_pixel(OP_BIN, 8'd254, 1'b0);
        send_pixel(OP_BIN, 8'd255, 1'b0);
        write_cutoff(8'd170);
        send_pixel(OP_ACC, 8'd171, 1'b1);
        send_pixel(OP_BIN, 8'd170, 1'b0);
        // random frames, with a calm stretch in the middle
        while (sent < 1600) begin
            if ($urandom_range(4) == 0)
                write_cutoff(8'($urandom_range(3) == 0 ? $urandom_range(255)
                                                       : $urandom_range(90)));
            calm = (sent > 700 && sent < 950);
            run_frame($urandom_range(1, 40), $urandom_range(0, 20));
        end
        calm = 0;
        pause_idle();
        $display("covered %0d items, %0d thresholds, %0d binarized pixels",
                 sent, thr_seen, bin_seen);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2000ms;
        $display("tb: errors");
        $finish;
    end
endmodule

// ===== otsu_threshold_binarizer.f =====
hdl/otsu_pkg.sv
hdl/otsu_front.sv
hdl/otsu_mul.sv
hdl/otsu_back.sv
hdl/otsu_threshold_binarizer.sv
verif/otsu_checker.sv
verif/tb.sv
